// ===== hdl/pgmb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgmb_pkg
// Shared types and constants of the particle grid mass binning block:
// function codes, register indexes, fixed-point constants and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pgmb_pkg;

	// Item function codes
	localparam logic [1:0] FUNC_DEPOSIT = 2'd0;
	localparam logic [1:0] FUNC_QUERY   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR   = 2'd2;

	// Configuration register indexes
	localparam int         CFG_IDX_W           = 2;
	localparam logic [1:0] REG_INV_CELL_SIZE   = 2'd0;
	localparam logic [1:0] REG_INV_CELL_VOLUME = 2'd1;
	localparam logic [31:0] INV_RESET          = 32'd65536;

	// Fixed-point limits and constants
	localparam logic [47:0] MASS_MAX  = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	// 273.15 in Q16.16, rounded to nearest
	localparam logic [62:0] TEMP_BASE = 63'd17901158;
	localparam logic [4:0]  DIV_TEN   = 5'd10;

	// Divide by ten: quotient bits retired per cycle and number of cycles
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = 64 / DIV_BITS;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // capture input item
		logic mul_pos;   // position times reciprocal cell size
		logic addr_dep;  // cell address from position products
		logic addr_qry;  // cell address from query coordinates
		logic rd_en;     // read cell entry
		logic wr_dep;    // write back updated cell entry
		logic clr_wr;    // write zero entry, advance clear address
		logic dens_mul;  // mass times reciprocal volume halves
		logic dens_sum;  // combine and saturate density
		logic temp_mul;  // density times count, start divider
		logic div_step;  // retire quotient bits
		logic out_load;  // load result register
	} pgmb_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;  // clear address at last cell
		logic div_last;  // final divider step
	} pgmb_sts_t;

endpackage

// ===== hdl/pgmb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgmb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pgmb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/pgmb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgmb_ctrl
// Controller state machine: sequences deposit, query and clear items,
// the clearing pass after reset, and the result register handshake.
// ----------------------------------------------------------------------------
module pgmb_ctrl
	import pgmb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic [1:0] func,
	output logic      out_valid,
	input  logic      out_stall,
	output pgmb_cmd_t cmd,
	input  pgmb_sts_t sts
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_CLEAR   = 4'd1;
	localparam logic [3:0] ST_D_MUL   = 4'd2;
	localparam logic [3:0] ST_D_ADDR  = 4'd3;
	localparam logic [3:0] ST_D_READ  = 4'd4;
	localparam logic [3:0] ST_D_WRITE = 4'd5;
	localparam logic [3:0] ST_Q_ADDR  = 4'd6;
	localparam logic [3:0] ST_Q_READ  = 4'd7;
	localparam logic [3:0] ST_Q_DMUL  = 4'd8;
	localparam logic [3:0] ST_Q_DSUM  = 4'd9;
	localparam logic [3:0] ST_Q_TMUL  = 4'd10;
	localparam logic [3:0] ST_Q_DIV   = 4'd11;
	localparam logic [3:0] ST_Q_OUT   = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority case (func)
						FUNC_DEPOSIT: state_nxt = ST_D_MUL;
						FUNC_QUERY:   state_nxt = ST_Q_ADDR;
						FUNC_CLEAR:   state_nxt = ST_CLEAR;
						default:      state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR:   state_nxt = sts.clr_last ? ST_IDLE : ST_CLEAR;
			ST_D_MUL:   state_nxt = ST_D_ADDR;
			ST_D_ADDR:  state_nxt = ST_D_READ;
			ST_D_READ:  state_nxt = ST_D_WRITE;
			ST_D_WRITE: state_nxt = ST_IDLE;
			ST_Q_ADDR:  state_nxt = ST_Q_READ;
			ST_Q_READ:  state_nxt = ST_Q_DMUL;
			ST_Q_DMUL:  state_nxt = ST_Q_DSUM;
			ST_Q_DSUM:  state_nxt = ST_Q_TMUL;
			ST_Q_TMUL:  state_nxt = ST_Q_DIV;
			ST_Q_DIV:   state_nxt = sts.div_last ? ST_Q_OUT : ST_Q_DIV;
			ST_Q_OUT:   state_nxt = out_free ? ST_IDLE : ST_Q_OUT;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.clr_wr   = (state_q == ST_CLEAR);
		cmd.mul_pos  = (state_q == ST_D_MUL);
		cmd.addr_dep = (state_q == ST_D_ADDR);
		cmd.addr_qry = (state_q == ST_Q_ADDR);
		cmd.rd_en    = (state_q == ST_D_READ) || (state_q == ST_Q_READ);
		cmd.wr_dep   = (state_q == ST_D_WRITE);
		cmd.dens_mul = (state_q == ST_Q_DMUL);
		cmd.dens_sum = (state_q == ST_Q_DSUM);
		cmd.temp_mul = (state_q == ST_Q_TMUL);
		cmd.div_step = (state_q == ST_Q_DIV);
		cmd.out_load = (state_q == ST_Q_OUT) && out_free;
	end

	// State register; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Result valid: set on load, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/pgmb_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgmb_dpath
// Datapath: configuration registers, cell index arithmetic, cell store,
// density and temperature arithmetic with a radix-16 divide by ten, and
// the result register.
// ----------------------------------------------------------------------------
module pgmb_dpath
	import pgmb_pkg::*;
#(
	parameter int GRID_SIZE = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pgmb_cmd_t            cmd,
	output pgmb_sts_t            sts,
	input  logic                 cfg_wr,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic [31:0]          particle_mass,
	input  logic [5:0]           query_x,
	input  logic [5:0]           query_y,
	output logic [15:0]          cell_count,
	output logic [47:0]          cell_mass,
	output logic [47:0]          cell_density,
	output logic [62:0]          cell_temperature
);

	localparam int CELLS = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(CELLS);
	localparam int IW    = $clog2(GRID_SIZE);
	localparam logic [30:0] IDX_MAX_P = 31'(GRID_SIZE - 1);
	localparam logic [10:0] IDX_MAX_Q = 11'(GRID_SIZE - 1);
	localparam logic [IW-1:0] IDX_MAX = IW'(GRID_SIZE - 1);
	localparam logic [AW-1:0] GRID_A  = AW'(GRID_SIZE);
	localparam logic [AW-1:0] LAST_A  = AW'(CELLS - 1);

	// Configuration
	logic [31:0] inv_size_q;
	logic [31:0] inv_vol_q;

	// Captured item
	logic [31:0] pos_x_q;
	logic [31:0] pos_y_q;
	logic [31:0] pmass_q;
	logic [5:0]  qx_q;
	logic [5:0]  qy_q;

	// Index arithmetic
	logic [62:0]   prod_x_q;
	logic [62:0]   prod_y_q;
	logic          neg_x_q;
	logic          neg_y_q;
	logic [IW-1:0] dep_x;
	logic [IW-1:0] dep_y;
	logic [IW-1:0] qry_x;
	logic [IW-1:0] qry_y;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] clr_addr_q;

	// Store access
	logic [63:0]   rd_data;
	logic [63:0]   wr_data;
	logic [AW-1:0] wr_addr;
	logic          wr_en;
	logic [48:0]   mass_sum;
	logic [47:0]   mass_new;
	logic [15:0]   count_new;

	// Query arithmetic
	logic [15:0] cnt_q;
	logic [47:0] mass_q;
	logic [63:0] dens_hi_q;
	logic [63:0] dens_lo_q;
	logic [48:0] dens_sum;
	logic [47:0] dens_q;
	logic [63:0] div_q;
	logic [3:0]  rem_q;
	logic [DIV_CW-1:0] div_cnt_q;
	logic [63:0] div_nxt;
	logic [3:0]  rem_nxt;

	// Result register
	logic [15:0] res_count_q;
	logic [47:0] res_mass_q;
	logic [47:0] res_dens_q;
	logic [62:0] res_temp_q;

	// Configuration writes; unlisted indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_size_q <= INV_RESET;
			inv_vol_q  <= INV_RESET;
		end else if (cfg_wr) begin
			if (cfg_index == REG_INV_CELL_SIZE) begin
				inv_size_q <= cfg_data;
			end
			if (cfg_index == REG_INV_CELL_VOLUME) begin
				inv_vol_q <= cfg_data;
			end
		end
	end

	// Capture item on transfer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_x_q <= pos_x;
			pos_y_q <= pos_y;
			pmass_q <= particle_mass;
			qx_q    <= query_x;
			qy_q    <= query_y;
		end
	end

	// Scale position by reciprocal cell size (Q32.32 product)
	always_ff @(posedge clk) begin
		if (cmd.mul_pos) begin
			prod_x_q <= 63'(pos_x_q[30:0]) * 63'(inv_size_q);
			prod_y_q <= 63'(pos_y_q[30:0]) * 63'(inv_size_q);
			neg_x_q  <= pos_x_q[31];
			neg_y_q  <= pos_y_q[31];
		end
	end

	// Floor and clamp to the grid edges
	always_comb begin
		if (neg_x_q) begin
			dep_x = '0;
		end else if (prod_x_q[62:32] > IDX_MAX_P) begin
			dep_x = IDX_MAX;
		end else begin
			dep_x = prod_x_q[32 +: IW];
		end
		if (neg_y_q) begin
			dep_y = '0;
		end else if (prod_y_q[62:32] > IDX_MAX_P) begin
			dep_y = IDX_MAX;
		end else begin
			dep_y = prod_y_q[32 +: IW];
		end
		qry_x = (11'(qx_q) > IDX_MAX_Q) ? IDX_MAX : IW'(qx_q);
		qry_y = (11'(qy_q) > IDX_MAX_Q) ? IDX_MAX : IW'(qy_q);
	end

	// Cell address: column times grid size plus row
	always_ff @(posedge clk) begin
		if (cmd.addr_dep) begin
			addr_q <= AW'(dep_x) * GRID_A + AW'(dep_y);
		end else if (cmd.addr_qry) begin
			addr_q <= AW'(qry_x) * GRID_A + AW'(qry_y);
		end
	end

	// Clear address walks every cell, wraps at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= sts.clr_last ? '0 : clr_addr_q + AW'(1);
		end
	end

	assign sts.clr_last = (clr_addr_q == LAST_A);

	// Saturating deposit update; entry is {mass, count}
	always_comb begin
		mass_sum  = {1'b0, rd_data[63:16]} + 49'(pmass_q);
		mass_new  = mass_sum[48] ? MASS_MAX : mass_sum[47:0];
		count_new = (rd_data[15:0] == COUNT_MAX) ? COUNT_MAX : rd_data[15:0] + 16'd1;
		wr_en     = cmd.clr_wr || cmd.wr_dep;
		wr_addr   = cmd.clr_wr ? clr_addr_q : addr_q;
		wr_data   = cmd.clr_wr ? 64'd0 : {mass_new, count_new};
	end

	pgmb_ram #(
		.WIDTH(64),
		.DEPTH(CELLS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(addr_q),
		.rd_data(rd_data)
	);

	// Density partial products from the upper and lower volume halves
	always_ff @(posedge clk) begin
		if (cmd.dens_mul) begin
			cnt_q     <= rd_data[15:0];
			mass_q    <= rd_data[63:16];
			dens_hi_q <= 64'(rd_data[63:16]) * 64'(inv_vol_q[31:16]);
			dens_lo_q <= 64'(rd_data[63:16]) * 64'(inv_vol_q[15:0]);
		end
	end

	// Combine and saturate density
	assign dens_sum = 49'(dens_hi_q) + 49'(dens_lo_q[63:16]);

	always_ff @(posedge clk) begin
		if (cmd.dens_sum) begin
			if (dens_hi_q > 64'(MASS_MAX) || dens_sum[48]) begin
				dens_q <= MASS_MAX;
			end else begin
				dens_q <= dens_sum[47:0];
			end
		end
	end

	// Restoring divide by ten, several quotient bits per cycle
	always_comb begin
		logic [4:0] part;
		div_nxt = div_q;
		rem_nxt = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			part = {rem_nxt, div_nxt[63]};
			if (part >= DIV_TEN) begin
				part    = part - DIV_TEN;
				div_nxt = {div_nxt[62:0], 1'b1};
			end else begin
				div_nxt = {div_nxt[62:0], 1'b0};
			end
			rem_nxt = part[3:0];
		end
	end

	// Density times count, then shift quotient in place of dividend
	always_ff @(posedge clk) begin
		if (cmd.temp_mul) begin
			div_q     <= 64'(dens_q) * 64'(cnt_q);
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_q     <= div_nxt;
			rem_q     <= rem_nxt;
			div_cnt_q <= div_cnt_q + DIV_CW'(1);
		end
	end

	assign sts.div_last = (div_cnt_q == DIV_CW'(DIV_STEPS - 1));

	// Result register; an empty cell reads as all zeros
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cnt_q == 16'd0) begin
				res_count_q <= '0;
				res_mass_q  <= '0;
				res_dens_q  <= '0;
				res_temp_q  <= '0;
			end else begin
				res_count_q <= cnt_q;
				res_mass_q  <= mass_q;
				res_dens_q  <= dens_q;
				res_temp_q  <= TEMP_BASE + div_q[62:0];
			end
		end
	end

	assign cell_count       = res_count_q;
	assign cell_mass        = res_mass_q;
	assign cell_density     = res_dens_q;
	assign cell_temperature = res_temp_q;

endmodule

// ===== hdl/particle_grid_mass_binning.sv =====
`timescale 1ns / 1ps
// Deposit: accepted, then multiply, address, read and write back before ready again.
// Query: address, read, density multiply and sum, temperature multiply, divide by ten, then result load.
// Clear: every cell is zeroed, one cell written per cycle by the store's write port.
// One item at a time; a waiting result does not block deposits or clears.
// Reset: async active low; afterwards a clearing pass over all GRID_SIZE*GRID_SIZE cells
// (4096 by default) runs with input stalled; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// particle_grid_mass_binning
// Bins particle mass and count into a square grid of cells and answers
// cell queries with count, mass, density and temperature.
// ----------------------------------------------------------------------------
module particle_grid_mass_binning
	import pgmb_pkg::*;
#(
	parameter int GRID_SIZE = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           func,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic [31:0]          particle_mass,
	input  logic [5:0]           query_x,
	input  logic [5:0]           query_y,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [15:0]          cell_count,
	output logic [47:0]          cell_mass,
	output logic [47:0]          cell_density,
	output logic [62:0]          cell_temperature
);

	pgmb_cmd_t cmd;
	pgmb_sts_t sts;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	pgmb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	pgmb_dpath #(
		.GRID_SIZE(GRID_SIZE)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.particle_mass   (particle_mass),
		.query_x         (query_x),
		.query_y         (query_y),
		.cell_count      (cell_count),
		.cell_mass       (cell_mass),
		.cell_density    (cell_density),
		.cell_temperature(cell_temperature)
	);

endmodule

// ===== hdl/pgmb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgmb_checker
// Port-level checks of the binning block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pgmb_checker
	import pgmb_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0]          cfg_data,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [1:0]           func,
	input logic signed [31:0]   pos_x,
	input logic signed [31:0]   pos_y,
	input logic [31:0]          particle_mass,
	input logic [5:0]           query_x,
	input logic [5:0]           query_y,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [15:0]          cell_count,
	input logic [47:0]          cell_mass,
	input logic [47:0]          cell_density,
	input logic [62:0]          cell_temperature
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cell_count) && $stable(cell_mass)
			&& $stable(cell_density) && $stable(cell_temperature))
		else $error("stalled result changed");

	// Busy after any transfer with a valid function
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (func == FUNC_DEPOSIT || func == FUNC_QUERY
			|| func == FUNC_CLEAR) |=> in_stall)
		else $error("input not stalled after transfer");

	// Empty cell reads as all zeros
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cell_count == 16'd0 |-> cell_mass == 48'd0 && cell_density == 48'd0
			&& cell_temperature == 63'd0)
		else $error("empty cell result not zero");

	// Occupied cell never reads below the temperature base
	a_temp_base: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cell_count != 16'd0 |-> cell_temperature >= TEMP_BASE)
		else $error("temperature below base");

endmodule

bind particle_grid_mass_binning pgmb_checker u_pgmb_checker (.*);
